### design/rsq_pkg.sv
// Shared types, constants and the LFSR step of the randomized slot queue.
`default_nettype none
package rsq_pkg;

  localparam int SLOTS_DEFAULT = 16;
  localparam int VALUE_W       = 32;
  localparam int COUNT_W       = 5;
  localparam int CAP_FIELD_MAX = 31;
  localparam int RND_W         = 16;
  localparam int MOD_BITS      = 4;
  localparam int MOD_STEPS     = RND_W / MOD_BITS;
  localparam int MOD_CNT_W     = $clog2(MOD_STEPS);
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 16;

  localparam logic [COUNT_W-1:0] CAP_RESET  = 5'd16;
  localparam logic [RND_W-1:0]   SEED_RESET = 16'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RANDOM_SEED = 1'b0,
    REG_CAPACITY    = 1'b1
  } rsq_cfg_reg_t;

  typedef enum logic [0:0] {
    KIND_PUT = 1'b0,
    KIND_GET = 1'b1
  } rsq_kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUT,
    S_GET,
    S_MOD,
    S_CHECK,
    S_DONE
  } rsq_state_t;

  typedef struct packed {
    logic                      kind;
    logic signed [VALUE_W-1:0] put_value;
  } rsq_req_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] got_value;
    logic                      was_empty;
    logic                      was_full;
    logic [COUNT_W-1:0]        occupancy;
  } rsq_rsp_t;

  typedef struct packed {
    logic               start;
    logic [RND_W-1:0]   dividend;
    logic [COUNT_W-1:0] divisor;
  } rsq_mod_req_t;

  function automatic logic [RND_W-1:0] lfsr_step(input logic [RND_W-1:0] cur);
    logic [RND_W-1:0] s;
    logic             fb;
    s  = (cur == '0) ? SEED_RESET : cur;
    fb = s[0] ^ s[2] ^ s[3] ^ s[5];
    return {fb, s[RND_W-1:1]};
  endfunction

endpackage
`default_nettype wire

### design/rsq_chan_if.sv
// Valid/ready channel carrying one payload beat.
`default_nettype none
interface rsq_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

### design/rsq_mod.sv
// Iterative remainder unit: 16-bit draw modulo a 5-bit divisor, four bits a cycle.
`default_nettype none
module rsq_mod
  import rsq_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire rsq_mod_req_t       req,
  output logic                    done,
  output logic [COUNT_W-1:0]      rem
);

  logic                 busy;
  logic [MOD_CNT_W-1:0] cnt;
  logic [RND_W-1:0]     shreg;
  logic [COUNT_W-1:0]   divisor;
  logic [COUNT_W-1:0]   rem_next;

  always_comb begin
    logic [COUNT_W:0] t;
    rem_next = rem;
    for (int k = 0; k < MOD_BITS; k++) begin
      t = {rem_next, shreg[RND_W-1-k]};
      if (t >= {1'b0, divisor}) begin
        t = t - {1'b0, divisor};
      end
      rem_next = t[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy    <= 1'b1;
        cnt     <= '0;
        shreg   <= req.dividend;
        divisor <= req.divisor;
        rem     <= '0;
      end else if (busy) begin
        rem   <= rem_next;
        shreg <= shreg << MOD_BITS;
        cnt   <= cnt + 1'b1;
        if (cnt == MOD_CNT_W'(MOD_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

### design/rsq_mem.sv
// Slot value memory: one write port, one registered read port.
`default_nettype none
module rsq_mem
  import rsq_pkg::*;
#(
  parameter int DEPTH = SLOTS_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [AW-1:0]             waddr,
  input  wire logic signed [VALUE_W-1:0] wdata,
  input  wire logic                      re,
  input  wire logic [AW-1:0]             raddr,
  output logic signed [VALUE_W-1:0]      rdata
);

  logic signed [VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### design/randomized_slot_queue.sv
// Randomized slot queue: put into the lowest free slot, get a random element.
//
// Channels: req carries kind and put_value, rsp carries got_value, was_empty,
// was_full and occupancy; a beat moves when valid and ready are both high.
// Every request beat yields exactly one response beat, in order.
// Configuration: cfg_we with cfg_index selects random_seed (0) or capacity (1);
// a seed write reloads the LFSR. Write only while no request is in flight.
// One item is in work at a time. A put, and a get on an empty table, pass
// through the put or get step and the final step to the response register.
// Any other get draws a slot: each draw runs the remainder unit (four quotient
// bits a cycle) and then a check of the occupied flags; redraws follow while
// the drawn slot is free, except that if the first draw misses and no occupied
// slot lies below the capacity, the lowest occupied slot is taken. The value
// is read from the slot memory through its registered read port. The next
// request is accepted only after the response is registered.
// A response waits in an output register while rsp.ready is low; the next
// request is accepted meanwhile and holds in its final step until the
// register frees. Reset clears occupied flags, count and the response valid
// flag, sets capacity to 16 and the LFSR to 1.
`default_nettype none
module randomized_slot_queue
  import rsq_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  rsq_chan_if.sink                   req,
  rsq_chan_if.source                 rsp,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int USED = (SLOTS < CAP_FIELD_MAX) ? SLOTS : CAP_FIELD_MAX;
  localparam int IW   = $clog2(USED);
  localparam logic [COUNT_W-1:0] CAP_MAX = COUNT_W'(USED);

  rsq_state_t state, state_next;

  logic                      kind_r;
  logic signed [VALUE_W-1:0] val_r;
  logic [RND_W-1:0]          lfsr;
  logic [RND_W-1:0]          lfsr_next;
  logic [COUNT_W-1:0]        capacity;
  logic [COUNT_W-1:0]        cap_eff;
  logic [USED-1:0]           flags;
  logic [COUNT_W-1:0]        count;
  logic [IW-1:0]             pos;
  logic                      first;
  logic                      res_got;
  logic                      res_empty;
  logic                      res_full;
  logic                      out_valid;
  rsq_rsp_t                  out_r;

  logic [IW-1:0] free_idx;
  logic          low_in_ok;
  logic [IW-1:0] low_any_idx;
  logic          is_full;
  logic          hit;
  logic          out_free;
  logic          accept;

  logic          draw_en;
  logic          take;
  logic          do_put;
  logic [IW-1:0] take_idx;
  rsq_mod_req_t  mod_req;
  logic          mod_done;
  logic [COUNT_W-1:0] mod_rem;
  logic signed [VALUE_W-1:0] rdata;

  assign cap_eff   = (capacity == '0) ? COUNT_W'(1) :
                     (capacity > CAP_MAX) ? CAP_MAX : capacity;
  assign is_full   = count >= cap_eff;
  assign hit       = flags[pos];
  assign out_free  = !out_valid || rsp.ready;
  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign lfsr_next = lfsr_step(lfsr);
  assign rsp.valid   = out_valid;
  assign rsp.payload = out_r;

  always_comb begin
    free_idx    = '0;
    low_in_ok   = 1'b0;
    low_any_idx = '0;
    for (int i = USED - 1; i >= 0; i--) begin
      if (!flags[i] && (COUNT_W'(i) < cap_eff)) begin
        free_idx = IW'(i);
      end
      if (flags[i] && (COUNT_W'(i) < cap_eff)) begin
        low_in_ok  = 1'b1;
      end
      if (flags[i]) begin
        low_any_idx = IW'(i);
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (req.payload.kind == KIND_GET) ? S_GET : S_PUT;
        end
      end
      S_PUT:   state_next = S_DONE;
      S_GET:   state_next = (count == '0) ? S_DONE : S_MOD;
      S_MOD: begin
        if (mod_done) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: state_next = take ? S_DONE : S_MOD;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    draw_en          = 1'b0;
    take             = 1'b0;
    do_put           = 1'b0;
    take_idx         = pos;
    mod_req.start    = 1'b0;
    mod_req.dividend = lfsr_next;
    mod_req.divisor  = cap_eff;
    unique case (state)
      S_PUT: begin
        do_put = !is_full;
      end
      S_GET: begin
        if (count != '0) begin
          draw_en         = 1'b1;
          mod_req.start   = 1'b1;
          mod_req.divisor = count;
        end
      end
      S_CHECK: begin
        if (hit) begin
          take = 1'b1;
        end else if (first && !low_in_ok) begin
          take     = 1'b1;
          take_idx = low_any_idx;
        end else begin
          draw_en       = 1'b1;
          mod_req.start = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  rsq_mod u_mod (
    .clk  (clk),
    .rst  (rst),
    .req  (mod_req),
    .done (mod_done),
    .rem  (mod_rem)
  );

  rsq_mem #(
    .DEPTH (USED),
    .AW    (IW)
  ) u_mem (
    .clk   (clk),
    .we    (do_put),
    .waddr (free_idx),
    .wdata (val_r),
    .re    (take),
    .raddr (take_idx),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      lfsr      <= SEED_RESET;
      capacity  <= CAP_RESET;
      flags     <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_we && cfg_index == REG_RANDOM_SEED) begin
        lfsr <= cfg_data[RND_W-1:0];
      end else if (draw_en) begin
        lfsr <= lfsr_next;
      end
      if (cfg_we && cfg_index == REG_CAPACITY) begin
        capacity <= cfg_data[COUNT_W-1:0];
      end

      if (do_put) begin
        flags[free_idx] <= 1'b1;
        count           <= count + COUNT_W'(1);
      end else if (take) begin
        flags[take_idx] <= 1'b0;
        count           <= count - COUNT_W'(1);
      end

      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r    <= req.payload.kind;
      val_r     <= req.payload.put_value;
      first     <= 1'b1;
      res_got   <= 1'b0;
      res_empty <= 1'b0;
      res_full  <= 1'b0;
    end
    if (state == S_PUT && is_full) begin
      res_full <= 1'b1;
    end
    if (state == S_GET && count == '0) begin
      res_empty <= 1'b1;
    end
    if (state == S_MOD && mod_done) begin
      pos <= mod_rem[IW-1:0];
    end
    if (state == S_CHECK) begin
      if (take) begin
        res_got <= 1'b1;
      end else begin
        first <= 1'b0;
      end
    end
    if (state == S_DONE && out_free) begin
      out_r.got_value <= res_got ? rdata : '0;
      out_r.was_empty <= res_empty;
      out_r.was_full  <= res_full;
      out_r.occupancy <= count;
    end
  end

  a_count_matches_flags: assert property (@(posedge clk) disable iff (rst)
    COUNT_W'($countones(flags)) == count)
    else $error("occupied flags disagree with entry count");

  a_take_occupied: assert property (@(posedge clk) disable iff (rst)
    take |-> flags[take_idx])
    else $error("get frees a slot that is not occupied");

  a_put_free: assert property (@(posedge clk) disable iff (rst)
    do_put |-> !flags[free_idx] && kind_r == KIND_PUT)
    else $error("put writes into an occupied slot");

  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("response raised outside the final step");

endmodule
`default_nettype wire
